>>> design/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular deque core
// Operation and status codes, field widths and the control word that the
// top level broadcasts along the row of storage cells.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int WORD_W    = 32;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE       = 2'd0,
    STATUS_PUSH_FULL  = 2'd1,
    STATUS_POP_EMPTY  = 2'd2
  } status_t;

  typedef struct packed {
    logic  en;
    mode_t mode;
  } cell_ctrl_t;

endpackage

>>> design/cdq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_req_if: operation channel of the circular deque core
// Carries one deque operation per beat under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cdq_req_if;
  logic                         valid;
  logic                         ready;
  logic [cdq_pkg::MODE_W-1:0]   mode;
  logic signed [cdq_pkg::WORD_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

>>> design/cdq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_rsp_if: result channel of the circular deque core
// Carries one result per beat under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cdq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [cdq_pkg::WORD_W-1:0] popped_value;
  logic [cdq_pkg::STATUS_W-1:0]      status;
  logic signed [cdq_pkg::WORD_W-1:0] front_value;
  logic signed [cdq_pkg::WORD_W-1:0] back_value;
  logic                              is_empty;
  logic                              is_full;
  logic [cdq_pkg::OCC_W-1:0]         occupancy;

  modport source (output valid, output popped_value, output status, output front_value,
                  output back_value, output is_empty, output is_full, output occupancy,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input front_value,
                  input back_value, input is_empty, input is_full, input occupancy,
                  output ready);
endinterface

>>> design/cdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_cell: one storage cell of the deque row
// Holds one word and its valid bit, and takes data from either neighbour
// as the broadcast operation shifts the row towards the back or the front.
// ----------------------------------------------------------------------------
module cdq_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  cdq_pkg::cell_ctrl_t        ctrl,
  input  logic [cdq_pkg::WORD_W-1:0] value,
  input  logic [cdq_pkg::WORD_W-1:0] prev_data,
  input  logic                       prev_valid,
  input  logic [cdq_pkg::WORD_W-1:0] next_data,
  input  logic                       next_valid,
  output logic [cdq_pkg::WORD_W-1:0] data,
  output logic                       valid
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.en) begin
      unique case (ctrl.mode)
        cdq_pkg::MODE_PUSH_FRONT: valid <= prev_valid;
        cdq_pkg::MODE_PUSH_BACK:  valid <= prev_valid;
        cdq_pkg::MODE_POP_FRONT:  valid <= next_valid;
        cdq_pkg::MODE_POP_BACK:   valid <= next_valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      unique case (ctrl.mode)
        cdq_pkg::MODE_PUSH_FRONT: data <= prev_data;
        cdq_pkg::MODE_PUSH_BACK: begin
          if (!valid) data <= value;
        end
        cdq_pkg::MODE_POP_FRONT:  data <= next_data;
        cdq_pkg::MODE_POP_BACK:   data <= data;
      endcase
    end
  end

endmodule

>>> design/circular_deque_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_core: double-ended queue of up to DEPTH-1 words
//
//   channel | direction | payload
//   req     | in        | mode, value
//   rsp     | out       | popped_value, status, front_value, back_value,
//           |           | is_empty, is_full, occupancy
//
// For each operation the row of cells shifts in a single step and the
// result is registered, so one beat is accepted per cycle while the
// result register is empty or being drained. A stalled result holds req off.
// Reset empties the deque; no clearing pass is needed.
// ----------------------------------------------------------------------------
module circular_deque_core #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  cdq_req_if.sink   req,
  cdq_rsp_if.source rsp
);

  localparam int CAP = DEPTH - 1;
  localparam int CW  = $clog2(DEPTH);
  localparam int W   = cdq_pkg::WORD_W;

  logic [W-1:0]  cell_data [CAP];
  logic [CAP-1:0] cell_valid;
  logic [W-1:0]  nb_data   [CAP+1];
  logic [CAP:0]  nb_valid;
  logic [CAP-1:0] cell_last;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [W-1:0]  front;
  logic [W-1:0]  front_next;
  logic [W-1:0]  back;
  logic [W-1:0]  back_next;
  logic [W-1:0]  penult;
  logic [W-1:0]  popped;
  logic [CW+2:0] occ_wide;

  logic                 accept;
  logic                 empty;
  logic                 full;
  logic                 single;
  cdq_pkg::mode_t       mode;
  cdq_pkg::status_t     status;
  cdq_pkg::cell_ctrl_t  ctrl;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign mode      = cdq_pkg::mode_t'(req.mode);
  assign empty     = (count == '0);
  assign full      = (count == CW'(CAP));
  assign single    = (count == CW'(1));

  genvar g;
  generate
    for (g = 0; g < CAP; g++) begin : g_cell
      cdq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .value     (req.value),
        .prev_data ((g == 0) ? req.value : nb_data[(g == 0) ? 0 : g-1]),
        .prev_valid((g == 0) ? 1'b1 : nb_valid[(g == 0) ? 0 : g-1]),
        .next_data (nb_data[g+1]),
        .next_valid(nb_valid[g+1]),
        .data      (cell_data[g]),
        .valid     (cell_valid[g])
      );
      assign nb_data[g]   = cell_data[g];
      assign nb_valid[g]  = cell_valid[g];
      assign cell_last[g] = cell_valid[g] && !nb_valid[g+1];
    end
  endgenerate

  assign nb_data[CAP]  = '0;
  assign nb_valid[CAP] = 1'b0;

  always_comb begin
    penult = '0;
    for (int i = 0; i < CAP - 1; i++) begin
      penult = penult | (cell_data[i] & {W{cell_last[i+1]}});
    end
  end

  always_comb begin
    status     = cdq_pkg::STATUS_DONE;
    count_next = count;
    front_next = front;
    back_next  = back;
    popped     = '0;
    unique case (mode)
      cdq_pkg::MODE_PUSH_FRONT: begin
        if (full) begin
          status = cdq_pkg::STATUS_PUSH_FULL;
        end else begin
          count_next = count + CW'(1);
          front_next = req.value;
          if (empty) back_next = req.value;
        end
      end
      cdq_pkg::MODE_PUSH_BACK: begin
        if (full) begin
          status = cdq_pkg::STATUS_PUSH_FULL;
        end else begin
          count_next = count + CW'(1);
          back_next  = req.value;
          if (empty) front_next = req.value;
        end
      end
      cdq_pkg::MODE_POP_FRONT: begin
        if (empty) begin
          status = cdq_pkg::STATUS_POP_EMPTY;
        end else begin
          count_next = count - CW'(1);
          popped     = front;
          front_next = nb_valid[1] ? nb_data[1] : '0;
          if (single) back_next = '0;
        end
      end
      cdq_pkg::MODE_POP_BACK: begin
        if (empty) begin
          status = cdq_pkg::STATUS_POP_EMPTY;
        end else begin
          count_next = count - CW'(1);
          popped     = back;
          back_next  = single ? '0 : penult;
          if (single) front_next = '0;
        end
      end
    endcase
    ctrl.en   = accept && (status == cdq_pkg::STATUS_DONE);
    ctrl.mode = mode;
  end

  assign occ_wide = {3'b000, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      front <= '0;
      back  <= '0;
    end else if (accept) begin
      count <= count_next;
      front <= front_next;
      back  <= back_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.popped_value <= popped;
      rsp.status       <= status;
      rsp.front_value  <= front_next;
      rsp.back_value   <= back_next;
      rsp.is_empty     <= (count_next == '0);
      rsp.is_full      <= (count_next == CW'(CAP));
      rsp.occupancy    <= occ_wide[cdq_pkg::OCC_W-1:0];
    end
  end

endmodule
